>>> hw/rtl/tsp_pkg.sv
// ----------------------------------------------------------------------------
// tsp_pkg
// Shared constants, status codes and the result record of the TCP SYN
// header parser.
// ----------------------------------------------------------------------------
package tsp_pkg;

  // frame byte position, saturates at the capture limit
  localparam logic [15:0] MAX_CAPTURE  = 16'd65535;

  // link header lengths
  localparam logic [15:0] ETH_LINK_LEN = 16'd14;
  localparam logic [15:0] SLL_LINK_LEN = 16'd16;

  // IPv4 / TCP constants
  localparam logic [3:0]  IP_VERSION4  = 4'd4;
  localparam logic [5:0]  IP_MIN_LEN   = 6'd20;
  localparam logic [15:0] TCP_MIN_LEN  = 16'd20;
  localparam logic [7:0]  PROTO_TCP    = 8'h06;
  localparam logic [7:0]  FLAG_SYN     = 8'h02;
  localparam logic [7:0]  FLAG_ACK     = 8'h10;

  // byte offsets within the IPv4 header
  localparam logic [15:0] OFS_VER_IHL   = 16'd0;
  localparam logic [15:0] OFS_TLEN_HI   = 16'd2;
  localparam logic [15:0] OFS_TLEN_LO   = 16'd3;
  localparam logic [15:0] OFS_PROTO     = 16'd9;
  localparam logic [15:0] OFS_SRC_FIRST = 16'd12;
  localparam logic [15:0] OFS_SRC_LAST  = 16'd15;
  localparam logic [15:0] OFS_DST_FIRST = 16'd16;
  localparam logic [15:0] OFS_DST_LAST  = 16'd19;

  // byte offsets within the TCP header
  localparam logic [15:0] TCP_OFS_SPORT_LAST = 16'd1;
  localparam logic [15:0] TCP_OFS_DPORT_LAST = 16'd3;
  localparam logic [15:0] TCP_OFS_FLAGS      = 16'd13;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_TRUNCATED     = 3'd1,
    ST_BAD_VERSION   = 3'd2,
    ST_BAD_IHL       = 3'd3,
    ST_BAD_TOTAL_LEN = 3'd4,
    ST_NOT_TCP       = 3'd5,
    ST_NOT_SYN       = 3'd6
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic        ack_seen;
    logic [31:0] accepted_count;
  } result_t;

endpackage

>>> hw/rtl/tsp_if.sv
// ----------------------------------------------------------------------------
// tsp_if
// Valid/ready channels of the parser: frame byte beats in, result beats out.
// ----------------------------------------------------------------------------
interface tsp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] pkt_byte;
  logic       last_byte;

  modport source (output valid, output pkt_byte, output last_byte, input ready);
  modport sink   (input valid, input pkt_byte, input last_byte, output ready);
endinterface

interface tsp_res_if import tsp_pkg::*; ();
  logic        valid;
  logic        ready;
  status_t     status;
  logic [31:0] src_addr;
  logic [31:0] dst_addr;
  logic [15:0] src_port;
  logic [15:0] dst_port;
  logic        ack_seen;
  logic [31:0] accepted_count;

  modport source (output valid, output status, output src_addr, output dst_addr,
                  output src_port, output dst_port, output ack_seen,
                  output accepted_count, input ready);
  modport sink   (input valid, input status, input src_addr, input dst_addr,
                  input src_port, input dst_port, input ack_seen,
                  input accepted_count, output ready);
endinterface

>>> hw/rtl/tsp_frame_parse.sv
// ----------------------------------------------------------------------------
// tsp_frame_parse
// Per-frame field capture and end-of-frame judgement. One byte per step;
// on the last byte the result is formed and the frame state cleared.
// ----------------------------------------------------------------------------
module tsp_frame_parse import tsp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] pkt_byte,
  input  logic       last_byte,
  input  logic       link_kind,
  output result_t    result
);

  logic [15:0] byte_index_r, byte_index_nxt;
  logic [3:0]  ip_version_r, ip_version_nxt;
  logic [5:0]  ip_header_len_r, ip_header_len_nxt;
  logic [15:0] ip_total_len_r, ip_total_len_nxt;
  logic [7:0]  ip_protocol_r, ip_protocol_nxt;
  logic [31:0] src_addr_r, src_addr_nxt;
  logic [31:0] dst_addr_r, dst_addr_nxt;
  logic [15:0] src_port_r, src_port_nxt;
  logic [15:0] dst_port_r, dst_port_nxt;
  logic [7:0]  tcp_flags_r, tcp_flags_nxt;
  logic [31:0] good_count_r, good_count_nxt;

  logic [15:0] link_len;
  logic        take;
  logic [15:0] rel;
  logic [15:0] hdr_len_w;
  logic [15:0] tcp_ofs;
  logic [15:0] ip_size;
  status_t     status;

  assign link_len  = link_kind ? SLL_LINK_LEN : ETH_LINK_LEN;
  assign take      = (byte_index_r != MAX_CAPTURE);
  assign rel       = byte_index_r - link_len;
  assign hdr_len_w = {10'd0, ip_header_len_nxt};
  assign tcp_ofs   = rel - hdr_len_w;

  // field capture for the current byte
  always_comb begin
    byte_index_nxt    = byte_index_r;
    ip_version_nxt    = ip_version_r;
    ip_header_len_nxt = ip_header_len_r;
    ip_total_len_nxt  = ip_total_len_r;
    ip_protocol_nxt   = ip_protocol_r;
    src_addr_nxt      = src_addr_r;
    dst_addr_nxt      = dst_addr_r;
    src_port_nxt      = src_port_r;
    dst_port_nxt      = dst_port_r;
    tcp_flags_nxt     = tcp_flags_r;
    if (take) begin
      byte_index_nxt = byte_index_r + 16'd1;
      if (byte_index_r >= link_len) begin
        priority if (rel == OFS_VER_IHL) begin
          ip_version_nxt    = pkt_byte[7:4];
          ip_header_len_nxt = {pkt_byte[3:0], 2'b00};
        end else if (rel == OFS_TLEN_HI) begin
          ip_total_len_nxt = {pkt_byte, 8'h00};
        end else if (rel == OFS_TLEN_LO) begin
          ip_total_len_nxt = {ip_total_len_r[15:8], pkt_byte};
        end else if (rel == OFS_PROTO) begin
          ip_protocol_nxt = pkt_byte;
        end else if (rel >= OFS_SRC_FIRST && rel <= OFS_SRC_LAST) begin
          src_addr_nxt = {src_addr_r[23:0], pkt_byte};
        end else if (rel >= OFS_DST_FIRST && rel <= OFS_DST_LAST) begin
          dst_addr_nxt = {dst_addr_r[23:0], pkt_byte};
        end else begin
          ip_version_nxt = ip_version_r;
        end
        // tcp header bytes behind the ip header
        if (ip_header_len_nxt >= IP_MIN_LEN && rel >= hdr_len_w) begin
          priority if (tcp_ofs <= TCP_OFS_SPORT_LAST) begin
            src_port_nxt = {src_port_r[7:0], pkt_byte};
          end else if (tcp_ofs <= TCP_OFS_DPORT_LAST) begin
            dst_port_nxt = {dst_port_r[7:0], pkt_byte};
          end else if (tcp_ofs == TCP_OFS_FLAGS) begin
            tcp_flags_nxt = pkt_byte;
          end else begin
            tcp_flags_nxt = tcp_flags_r;
          end
        end
      end
    end
  end

  // end-of-frame checks, in order
  assign ip_size = byte_index_nxt - link_len;

  always_comb begin
    priority if (byte_index_nxt <= link_len) begin
      status = ST_TRUNCATED;
    end else if (ip_version_nxt != IP_VERSION4) begin
      status = ST_BAD_VERSION;
    end else if (ip_size < {10'd0, IP_MIN_LEN}) begin
      status = ST_TRUNCATED;
    end else if (ip_header_len_nxt < IP_MIN_LEN) begin
      status = ST_BAD_IHL;
    end else if (ip_total_len_nxt < hdr_len_w) begin
      status = ST_BAD_TOTAL_LEN;
    end else if (ip_total_len_nxt > ip_size) begin
      status = ST_TRUNCATED;
    end else if (ip_protocol_nxt != PROTO_TCP) begin
      status = ST_NOT_TCP;
    end else if ((ip_size - hdr_len_w) < TCP_MIN_LEN) begin
      status = ST_TRUNCATED;
    end else if ((tcp_flags_nxt & FLAG_SYN) == 8'h00) begin
      status = ST_NOT_SYN;
    end else begin
      status = ST_OK;
    end
  end

  assign good_count_nxt = (status == ST_OK) ? good_count_r + 32'd1 : good_count_r;

  // result record, fields zeroed on a failed frame
  always_comb begin
    result = '0;
    result.status = status;
    result.accepted_count = good_count_nxt;
    if (status == ST_OK) begin
      result.src_addr = src_addr_nxt;
      result.dst_addr = dst_addr_nxt;
      result.src_port = src_port_nxt;
      result.dst_port = dst_port_nxt;
      result.ack_seen = (tcp_flags_nxt & FLAG_ACK) != 8'h00;
    end
  end

  // frame state, cleared at the frame end
  always_ff @(posedge clk) begin
    if (!rst_n || (step && last_byte)) begin
      byte_index_r    <= '0;
      ip_version_r    <= '0;
      ip_header_len_r <= '0;
      ip_total_len_r  <= '0;
      ip_protocol_r   <= '0;
      src_addr_r      <= '0;
      dst_addr_r      <= '0;
      src_port_r      <= '0;
      dst_port_r      <= '0;
      tcp_flags_r     <= '0;
    end else if (step) begin
      byte_index_r    <= byte_index_nxt;
      ip_version_r    <= ip_version_nxt;
      ip_header_len_r <= ip_header_len_nxt;
      ip_total_len_r  <= ip_total_len_nxt;
      ip_protocol_r   <= ip_protocol_nxt;
      src_addr_r      <= src_addr_nxt;
      dst_addr_r      <= dst_addr_nxt;
      src_port_r      <= src_port_nxt;
      dst_port_r      <= dst_port_nxt;
      tcp_flags_r     <= tcp_flags_nxt;
    end
  end

  // accepted packet counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      good_count_r <= '0;
    end else if (step && last_byte) begin
      good_count_r <= good_count_nxt;
    end
  end

endmodule

>>> hw/rtl/tcp_syn_header_parser_core.sv
// Flow: a byte beat is taken into the input register and parsed from there;
//   the result of a last byte goes through the result register to out_beat.
// Throughput: 1 byte per cycle; the input register and the result register
//   each advance in a cycle, a result held by the sink stalls the next last byte
//   and the input waits behind it.
// Reset: synchronous active low; clears link_kind, frame state and the packet count.
// ----------------------------------------------------------------------------
// tcp_syn_header_parser_core
// Byte-stream IPv4/TCP SYN header parser with one result per frame.
// ----------------------------------------------------------------------------
module tcp_syn_header_parser_core import tsp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  tsp_byte_if.sink    in_beat,
  tsp_res_if.source   out_beat
);

  logic       link_kind_r;
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       out_valid_r;
  result_t    out_res_r;
  result_t    parse_res;
  logic       out_free;
  logic       s1_adv;
  logic       in_fire;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_kind_r <= 1'b0;
    end else if (cfg_we) begin
      link_kind_r <= cfg_wdata;
    end
  end

  // handshake
  assign out_free      = !out_valid_r || out_beat.ready;
  assign s1_adv        = s1_valid_r && (!s1_last_r || out_free);
  assign in_beat.ready = !s1_valid_r || s1_adv;
  assign in_fire       = in_beat.valid && in_beat.ready;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_beat.pkt_byte;
      s1_last_r <= in_beat.last_byte;
    end
  end

  tsp_frame_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s1_adv),
    .pkt_byte  (s1_byte_r),
    .last_byte (s1_last_r),
    .link_kind (link_kind_r),
    .result    (parse_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_beat.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last_r) begin
      out_res_r <= parse_res;
    end
  end

  assign out_beat.valid          = out_valid_r;
  assign out_beat.status         = out_res_r.status;
  assign out_beat.src_addr       = out_res_r.src_addr;
  assign out_beat.dst_addr       = out_res_r.dst_addr;
  assign out_beat.src_port       = out_res_r.src_port;
  assign out_beat.dst_port       = out_res_r.dst_port;
  assign out_beat.ack_seen       = out_res_r.ack_seen;
  assign out_beat.accepted_count = out_res_r.accepted_count;

  // a pending result is never overwritten while the sink stalls
  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_beat.ready |=> out_valid_r && $stable(out_res_r))
    else $error("result changed while stalled");

  // a failed frame reports no header fields
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.status != ST_OK |->
      out_res_r.src_addr == 32'd0 && out_res_r.dst_addr == 32'd0 &&
      out_res_r.src_port == 16'd0 && out_res_r.dst_port == 16'd0 &&
      !out_res_r.ack_seen)
    else $error("failed frame carries header fields");

  // input backpressure only comes from a last byte waiting on the result slot
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_beat.ready |-> s1_valid_r && s1_last_r && out_valid_r)
    else $error("input stalled without a pending last byte");

endmodule
